// ===== rtl/core/yfd_pkg.sv =====
// Package with the Y86-64 opcode, status and decode result definitions.
`timescale 1ns / 1ps

package yfd_pkg;

   localparam logic [3:0] ICODE_HALT   = 4'h0;
   localparam logic [3:0] ICODE_NOP    = 4'h1;
   localparam logic [3:0] ICODE_CMOV   = 4'h2;
   localparam logic [3:0] ICODE_IRMOVQ = 4'h3;
   localparam logic [3:0] ICODE_RMMOVQ = 4'h4;
   localparam logic [3:0] ICODE_MRMOVQ = 4'h5;
   localparam logic [3:0] ICODE_OPQ    = 4'h6;
   localparam logic [3:0] ICODE_JUMP   = 4'h7;
   localparam logic [3:0] ICODE_CALL   = 4'h8;
   localparam logic [3:0] ICODE_RET    = 4'h9;
   localparam logic [3:0] ICODE_PUSHQ  = 4'hA;
   localparam logic [3:0] ICODE_POPQ   = 4'hB;
   localparam logic [3:0] ICODE_IOTRAP = 4'hC;
   localparam logic [3:0] ICODE_FAULT  = 4'hF;

   localparam logic [3:0] NO_REG = 4'hF;

   localparam logic [1:0] STAT_OK  = 2'd0;
   localparam logic [1:0] STAT_ADR = 2'd1;
   localparam logic [1:0] STAT_INS = 2'd2;

   typedef struct packed {
      logic [15:0] pc;
      logic [7:0]  opcode_byte;
      logic [63:0] following_bytes;
      logic [7:0]  last_byte;
   } fetch_item_type;

   typedef struct packed {
      logic               valid_res;
      logic [3:0]         icode;
      logic [3:0]         ifun;
      logic [3:0]         reg_a;
      logic [3:0]         reg_b;
      logic signed [63:0] const_value;
      logic [16:0]        next_pc;
      logic [1:0]         status;
   } decode_result_type;

endpackage

// ===== rtl/core/y86_instruction_fetch_decode.sv =====
// Top level of the Y86-64 instruction fetch and decode block.
`timescale 1ns / 1ps

// Usage:
// The requester presents pc, the opcode byte, the eight following bytes and
// the byte at pc+9 on the req_ ports and raises start. A transfer takes place
// at each rising edge where start is high and busy is low; busy is always low,
// so one instruction may be transferred in every cycle.
// The decoded instruction is on the rsp_ ports in the cycle after the one it
// spends in the input register: it passes through the input register and the
// decode logic, then waits in the result register. rsp_valid is high for
// exactly that one cycle and the receiver must take the result then; it cannot
// hold the block off.
// Throughput is one instruction per cycle, set by the single decode stage.
// Faults (address or instruction errors) come back as ordinary results with
// valid_res low and the status code set.
// A synchronous reset clears both pipeline valid flags, so no result appears
// for an instruction that was in flight at reset.
module y86_instruction_fetch_decode
   import yfd_pkg::*;
#(
   parameter int MEM_SIZE = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_pc,
   input  logic [7:0]         req_opcode_byte,
   input  logic [63:0]        req_following_bytes,
   input  logic [7:0]         req_last_byte,
   output logic               rsp_valid,
   output logic               rsp_valid_res,
   output logic [3:0]         rsp_icode,
   output logic [3:0]         rsp_ifun,
   output logic [3:0]         rsp_reg_a,
   output logic [3:0]         rsp_reg_b,
   output logic signed [63:0] rsp_const_value,
   output logic [16:0]        rsp_next_pc,
   output logic [1:0]         rsp_status
);

   logic              item_valid_ff;
   logic              item_valid_in;
   fetch_item_type    item_ff;
   fetch_item_type    item_in;
   logic              res_valid_ff;
   logic              res_valid_in;
   decode_result_type res_ff;
   decode_result_type res_in;

   assign busy = 1'b0;

   assign item_valid_in           = start && !busy;
   assign item_in.pc              = req_pc;
   assign item_in.opcode_byte     = req_opcode_byte;
   assign item_in.following_bytes = req_following_bytes;
   assign item_in.last_byte       = req_last_byte;
   assign res_valid_in            = item_valid_ff;

   yfd_decode #(
      .MEM_SIZE (MEM_SIZE)
   ) u_decode (
      .item   (item_ff),
      .result (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid_in) begin
         item_ff <= item_in;
      end
      if (res_valid_in) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid       = res_valid_ff;
   assign rsp_valid_res   = res_ff.valid_res;
   assign rsp_icode       = res_ff.icode;
   assign rsp_ifun        = res_ff.ifun;
   assign rsp_reg_a       = res_ff.reg_a;
   assign rsp_reg_b       = res_ff.reg_b;
   assign rsp_const_value = res_ff.const_value;
   assign rsp_next_pc     = res_ff.next_pc;
   assign rsp_status      = res_ff.status;

`ifndef NO_ASSERTIONS
   a_transfer_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("transfer did not produce a result two cycles later");

   a_valid_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_valid_res == (rsp_status == STAT_OK)))
      else $error("valid_res disagrees with status");

   a_fault_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |->
         (rsp_icode == ICODE_FAULT && rsp_reg_a == NO_REG && rsp_reg_b == NO_REG
          && rsp_const_value == 64'sd0))
      else $error("fault result carries decoded fields");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(item_valid_ff))
      else $error("result without a decoded item");
`endif

endmodule

// ===== rtl/core/yfd_decode.sv =====
// Combinational decode of one registered instruction into its result fields.
`timescale 1ns / 1ps

module yfd_decode
   import yfd_pkg::*;
#(
   parameter int MEM_SIZE = 4096
) (
   input  fetch_item_type    item,
   output decode_result_type result
);

   localparam logic [16:0] MEM_LIMIT = 17'(MEM_SIZE);

   logic [3:0]  ic;
   logic [3:0]  fn;
   logic [3:0]  ra;
   logic [3:0]  rb;
   logic        fn_ok;
   logic        regs;
   logic        cval;
   logic        regs_ok;
   logic [16:0] pc_ext;
   logic [16:0] pc_plus1;
   logic [16:0] const_end;
   logic [16:0] len;

   assign ic       = item.opcode_byte[7:4];
   assign fn       = item.opcode_byte[3:0];
   assign ra       = item.following_bytes[7:4];
   assign rb       = item.following_bytes[3:0];
   assign pc_ext   = {1'b0, item.pc};
   assign pc_plus1 = pc_ext + 17'd1;

   always_comb begin
      fn_ok = 1'b0;
      regs  = 1'b0;
      cval  = 1'b0;
      unique case (ic)
         ICODE_HALT, ICODE_NOP, ICODE_RET: begin
            fn_ok = (fn == 4'd0);
         end
         ICODE_CMOV: begin
            fn_ok = (fn < 4'd7);
            regs  = 1'b1;
         end
         ICODE_IRMOVQ, ICODE_RMMOVQ, ICODE_MRMOVQ: begin
            fn_ok = (fn == 4'd0);
            regs  = 1'b1;
            cval  = 1'b1;
         end
         ICODE_OPQ: begin
            fn_ok = (fn < 4'd4);
            regs  = 1'b1;
         end
         ICODE_JUMP: begin
            fn_ok = (fn < 4'd7);
            cval  = 1'b1;
         end
         ICODE_CALL: begin
            fn_ok = (fn == 4'd0);
            cval  = 1'b1;
         end
         ICODE_PUSHQ, ICODE_POPQ: begin
            fn_ok = (fn == 4'd0);
            regs  = 1'b1;
         end
         ICODE_IOTRAP: begin
            fn_ok = (fn < 4'd6);
         end
         default: begin
            fn_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      priority if (ic == ICODE_IRMOVQ) begin
         regs_ok = (ra == NO_REG) && (rb != NO_REG);
      end else if (ic == ICODE_PUSHQ || ic == ICODE_POPQ) begin
         regs_ok = (ra != NO_REG) && (rb == NO_REG);
      end else if (ic == ICODE_RMMOVQ || ic == ICODE_MRMOVQ) begin
         regs_ok = (ra != NO_REG);
      end else begin
         regs_ok = (ra != NO_REG) && (rb != NO_REG);
      end
   end

   // Length is 1, plus 1 for the register byte, plus 8 for the constant.
   assign len       = 17'd1 + (regs ? 17'd1 : 17'd0) + (cval ? 17'd8 : 17'd0);
   assign const_end = pc_ext + len;

   always_comb begin
      result.valid_res   = 1'b0;
      result.icode       = ICODE_FAULT;
      result.ifun        = fn;
      result.reg_a       = NO_REG;
      result.reg_b       = NO_REG;
      result.const_value = '0;
      result.next_pc     = pc_ext;
      result.status      = STAT_OK;
      priority if (pc_ext >= MEM_LIMIT) begin
         result.ifun   = 4'd0;
         result.status = STAT_ADR;
      end else if (!fn_ok) begin
         result.status = STAT_INS;
      end else if (regs && pc_plus1 >= MEM_LIMIT) begin
         result.status = STAT_ADR;
      end else if (regs && !regs_ok) begin
         result.status = STAT_INS;
      end else if (cval && const_end > MEM_LIMIT) begin
         result.status = STAT_ADR;
      end else begin
         result.valid_res = 1'b1;
         result.icode     = ic;
         result.next_pc   = const_end;
         if (regs) begin
            result.reg_a = ra;
            result.reg_b = rb;
         end
         if (cval) begin
            result.const_value = regs ? {item.last_byte, item.following_bytes[63:8]}
                                      : item.following_bytes;
         end
      end
   end

endmodule
